/* sv/pkv_pkg.sv */
// Shared constants, codes and types for the paged KV block allocator.
package pkv_pkg;

  localparam int NUM_BLOCKS     = 64;
  localparam int NUM_SEQS       = 8;
  localparam int MAX_SEQ_BLOCKS = 64;
  localparam int SCORE_BITS     = 32;

  localparam int BLK_W     = $clog2(NUM_BLOCKS);
  localparam int SEQ_W     = $clog2(NUM_SEQS);
  localparam int RIDX_W    = $clog2(MAX_SEQ_BLOCKS);
  localparam int RCNT_W    = $clog2(MAX_SEQ_BLOCKS + 1);
  localparam int TOP_W     = $clog2(NUM_BLOCKS + 1);
  localparam int ITER_W    = $clog2(NUM_BLOCKS + 2);
  localparam int RING_DEPTH = NUM_SEQS * MAX_SEQ_BLOCKS;
  localparam int RING_AW   = SEQ_W + RIDX_W;

  localparam int KIND_W  = 2;
  localparam int SEQIN_W = 4;
  localparam int TOK_W   = 16;
  localparam int SCIN_W  = 16;
  localparam int BS_W    = 9;
  localparam int OFF_W   = 8;
  localparam int TRIM_W  = TOK_W + 1;
  localparam int MAXB_W  = 7;
  localparam int NSEQ_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 9;
  localparam int DIV_CNT_W = $clog2(TOK_W + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_BADSEQ   = 2'd2,
    ST_NOVICTIM = 2'd3
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    K_SETLEN  = 2'd0,
    K_ENSURE  = 2'd1,
    K_RESOLVE = 2'd2,
    K_SCORE   = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_SEQS  = 2'd3;

endpackage

/* sv/pkv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/paged_kv_block_allocator.sv */
// Paged KV block allocator: sequencer, per-sequence ring state, free stack and divider.
// Resolve, score, ensure and trim updates run the shared divider; ensure takes blocks from
//   the free stack or steals them from a victim sequence; a shrink frees its blocks one by one.
// Throughput: one transaction at a time; in_ready is high only while idle.
// Reset: synchronous, active low; restores config defaults, clears ring state and the free stack pointer.
//   The free stack needs no clearing pass: a low-water mark stands in for its initial image.
module paged_kv_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pkv_pkg::KIND_W-1:0]    in_kind,
  input  logic [pkv_pkg::SEQIN_W-1:0]   in_seq,
  input  logic [pkv_pkg::TOK_W-1:0]     in_token_pos,
  input  logic [pkv_pkg::TOK_W-1:0]     in_new_length,
  input  logic [pkv_pkg::SCIN_W-1:0]    in_score,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [pkv_pkg::BLK_W-1:0]     out_block_id,
  output logic [pkv_pkg::OFF_W-1:0]     out_offset,
  input  logic                          cfg_we,
  input  logic [pkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pkv_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_DIV, S_RD_BLK, S_FREE_RD, S_FREE_WR, S_EN_CHK,
    S_ALLOC_RD, S_ALLOC_WR, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_VIC,
    S_POP_DATA, S_PUSH, S_SC_PAD, S_SC_UPD, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic                         policy_r;
  logic [pkv_pkg::MAXB_W-1:0]   max_act_r;
  logic [pkv_pkg::BS_W-1:0]     btok_r;
  logic [pkv_pkg::NSEQ_W-1:0]   nseq_r;

  // captured transaction
  pkv_pkg::kind_t               kind_r;
  logic [pkv_pkg::SEQIN_W-1:0]  seq_r;
  logic [pkv_pkg::TOK_W-1:0]    tok_r;
  logic [pkv_pkg::TOK_W-1:0]    len_in_r;
  logic [pkv_pkg::SCIN_W-1:0]   sc_r;

  // per-sequence state
  logic [pkv_pkg::RIDX_W-1:0]   head_r [pkv_pkg::NUM_SEQS];
  logic [pkv_pkg::RCNT_W-1:0]   cnt_r  [pkv_pkg::NUM_SEQS];
  logic [pkv_pkg::RCNT_W-1:0]   scnt_r [pkv_pkg::NUM_SEQS];
  logic [pkv_pkg::TRIM_W-1:0]   trim_r [pkv_pkg::NUM_SEQS];
  logic [pkv_pkg::TOK_W-1:0]    len_r  [pkv_pkg::NUM_SEQS];

  // free pool
  logic [pkv_pkg::TOP_W-1:0]      free_top_r;
  logic [pkv_pkg::TOP_W-1:0]      min_top_r;
  logic [pkv_pkg::NUM_BLOCKS-1:0] in_use_r;

  // shared divider: quotient doubles as the ring index of the token
  logic [pkv_pkg::TOK_W-1:0]     div_quo_r;
  logic [pkv_pkg::OFF_W-1:0]     div_rem_r;
  logic [pkv_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [pkv_pkg::TOK_W-1:0]     diff_r;

  // ensure loop and victim search
  logic [pkv_pkg::ITER_W-1:0]    iter_r;
  logic                          behind_r;
  logic [pkv_pkg::SEQ_W-1:0]     scan_r;
  logic [pkv_pkg::SEQ_W-1:0]     most_best_r;
  logic [pkv_pkg::RCNT_W-1:0]    most_cnt_r;
  logic                          sc_found_r;
  logic [pkv_pkg::SEQ_W-1:0]     sc_best_r;
  logic                          sc_rank_r;
  logic [pkv_pkg::SCORE_BITS-1:0] sc_val_r;
  logic [pkv_pkg::SEQ_W-1:0]     vic_r;
  logic [pkv_pkg::BLK_W-1:0]     b_r;
  logic [pkv_pkg::RCNT_W-1:0]    free_i_r;

  // result
  pkv_pkg::status_t              res_st_r;
  logic [pkv_pkg::BLK_W-1:0]     res_blk_r;
  logic [pkv_pkg::OFF_W-1:0]     res_off_r;
  logic                          out_valid_r;
  pkv_pkg::status_t              out_status_r;
  logic [pkv_pkg::BLK_W-1:0]     out_blk_r;
  logic [pkv_pkg::OFF_W-1:0]     out_off_r;

  // derived values
  logic [pkv_pkg::BS_W-1:0]      bs;
  logic [pkv_pkg::NSEQ_W-1:0]    nseq_eff;
  logic [pkv_pkg::SEQ_W-1:0]     s_idx;
  logic [pkv_pkg::SEQ_W-1:0]     cidx;
  logic [pkv_pkg::RIDX_W-1:0]    head_c;
  logic [pkv_pkg::RCNT_W-1:0]    cnt_c;
  logic [pkv_pkg::RCNT_W-1:0]    scnt_c;
  logic [pkv_pkg::TRIM_W-1:0]    trim_c;
  logic [pkv_pkg::TOK_W-1:0]     len_c;
  logic [pkv_pkg::RIDX_W-1:0]    ring_off;
  logic [pkv_pkg::RIDX_W-1:0]    sc_roff;
  logic [pkv_pkg::RIDX_W-1:0]    sc_woff;
  logic [pkv_pkg::TOK_W-1:0]     trim_lo;
  logic                          tok_behind;
  logic [pkv_pkg::TOK_W-1:0]     tok_diff;
  logic [pkv_pkg::TOK_W-1:0]     shrink_t;
  logic [pkv_pkg::BS_W-1:0]      div_sh;
  logic                          div_ge;
  logic [pkv_pkg::BS_W-1:0]      div_sub;
  logic [pkv_pkg::TRIM_W:0]      trim_sum;
  logic [pkv_pkg::TRIM_W-1:0]    trim_inc;
  logic [pkv_pkg::SCORE_BITS:0]  score_sum;
  logic [pkv_pkg::SCORE_BITS-1:0] score_sat;
  logic [pkv_pkg::TOP_W-1:0]     top_dec;
  logic [pkv_pkg::TOP_W-1:0]     active_blk;
  logic                          need_steal;
  logic                          free_ok;
  logic [pkv_pkg::BLK_W-1:0]     pop_blk;
  logic                          sc_rank;
  logic                          sc_better;
  logic                          scan_last;

  // memory ports
  logic                            ring_we;
  logic [pkv_pkg::RING_AW-1:0]     ring_waddr;
  logic [pkv_pkg::RING_AW-1:0]     ring_raddr;
  logic [pkv_pkg::BLK_W-1:0]       ring_rdata;
  logic                            score_we;
  logic [pkv_pkg::RING_AW-1:0]     score_waddr;
  logic [pkv_pkg::SCORE_BITS-1:0]  score_wdata;
  logic [pkv_pkg::RING_AW-1:0]     score_raddr;
  logic [pkv_pkg::SCORE_BITS-1:0]  score_rdata;
  logic                            stack_we;
  logic [pkv_pkg::BLK_W-1:0]       stack_waddr;
  logic [pkv_pkg::BLK_W-1:0]       stack_raddr;
  logic [pkv_pkg::BLK_W-1:0]       stack_rdata;

  // Clamp block size to 1..256 and the slot count to the number of slots built.
  always_comb begin
    if (btok_r == '0) begin
      bs = pkv_pkg::BS_W'(1);
    end else if (btok_r > pkv_pkg::BS_W'(256)) begin
      bs = pkv_pkg::BS_W'(256);
    end else begin
      bs = btok_r;
    end
    if (nseq_r > pkv_pkg::NSEQ_W'(pkv_pkg::NUM_SEQS)) begin
      nseq_eff = pkv_pkg::NSEQ_W'(pkv_pkg::NUM_SEQS);
    end else begin
      nseq_eff = nseq_r;
    end
  end

  assign s_idx = seq_r[pkv_pkg::SEQ_W-1:0];

  // One index selects the per-sequence entry for both reads and writes.
  always_comb begin
    case (state_r)
      S_SCAN_RD, S_SCAN_CMP: cidx = scan_r;
      S_VIC:                 cidx = vic_r;
      default:               cidx = s_idx;
    endcase
  end

  assign head_c = head_r[cidx];
  assign cnt_c  = cnt_r[cidx];
  assign scnt_c = scnt_r[cidx];
  assign trim_c = trim_r[cidx];
  assign len_c  = len_r[cidx];

  assign trim_lo    = trim_c[pkv_pkg::TOK_W-1:0];
  assign tok_behind = {1'b0, tok_r} < trim_c;
  assign tok_diff   = tok_r - trim_lo;
  assign shrink_t   = (len_in_r > pkv_pkg::TOK_W'(bs)) ? (len_in_r - pkv_pkg::TOK_W'(bs)) : '0;

  // Restoring divider step: one quotient bit per cycle.
  assign div_sh  = {div_rem_r, div_quo_r[pkv_pkg::TOK_W-1]};
  assign div_ge  = div_sh >= bs;
  assign div_sub = div_sh - bs;

  assign trim_sum = {1'b0, trim_c} + (pkv_pkg::TRIM_W + 1)'(bs);
  assign trim_inc = trim_sum[pkv_pkg::TRIM_W] ? '1 : trim_sum[pkv_pkg::TRIM_W-1:0];

  assign score_sum = {1'b0, score_rdata} + (pkv_pkg::SCORE_BITS + 1)'(sc_r);
  assign score_sat = score_sum[pkv_pkg::SCORE_BITS] ? '1 : score_sum[pkv_pkg::SCORE_BITS-1:0];

  assign top_dec    = free_top_r - pkv_pkg::TOP_W'(1);
  assign active_blk = pkv_pkg::TOP_W'(pkv_pkg::NUM_BLOCKS) - free_top_r;
  assign need_steal = ((max_act_r != '0) && (active_blk >= pkv_pkg::TOP_W'(max_act_r)))
                      || (free_top_r == '0);
  assign free_ok    = in_use_r[ring_rdata] && (free_top_r < pkv_pkg::TOP_W'(pkv_pkg::NUM_BLOCKS));
  // Stack entries below the low-water mark were never written; each stands for the block of its own index.
  assign pop_blk    = (free_top_r == min_top_r) ? top_dec[pkv_pkg::BLK_W-1:0] : stack_rdata;

  assign sc_rank   = (scan_r == s_idx);
  assign sc_better = !sc_found_r || (!sc_rank && sc_rank_r)
                     || ((sc_rank == sc_rank_r) && (score_rdata < sc_val_r));
  assign scan_last = ({1'b0, scan_r} + pkv_pkg::NSEQ_W'(1)) == nseq_eff;

  // Memory addressing.
  always_comb begin
    case (state_r)
      S_VIC:     ring_off = '0;
      S_FREE_RD: ring_off = free_i_r[pkv_pkg::RIDX_W-1:0];
      default:   ring_off = div_quo_r[pkv_pkg::RIDX_W-1:0];
    endcase
    case (state_r)
      S_SCAN_RD, S_SCAN_CMP: sc_roff = '0;
      default:               sc_roff = div_quo_r[pkv_pkg::RIDX_W-1:0];
    endcase
    if (state_r == S_SC_PAD) begin
      sc_woff = scnt_c[pkv_pkg::RIDX_W-1:0];
    end else begin
      sc_woff = div_quo_r[pkv_pkg::RIDX_W-1:0];
    end
  end

  assign ring_raddr  = {cidx, head_c + ring_off};
  assign ring_we     = (state_r == S_PUSH);
  assign ring_waddr  = {cidx, head_c + cnt_c[pkv_pkg::RIDX_W-1:0]};

  assign score_raddr = {cidx, head_c + sc_roff};
  assign score_we    = ((state_r == S_SC_PAD) && (scnt_c < cnt_c)) || (state_r == S_SC_UPD);
  assign score_waddr = {cidx, head_c + sc_woff};
  assign score_wdata = (state_r == S_SC_PAD) ? '0 : score_sat;

  assign stack_raddr = top_dec[pkv_pkg::BLK_W-1:0];
  assign stack_we    = (state_r == S_FREE_WR) && free_ok;
  assign stack_waddr = free_top_r[pkv_pkg::BLK_W-1:0];

  pkv_ram #(.WIDTH(pkv_pkg::BLK_W), .DEPTH(pkv_pkg::RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (b_r),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  pkv_ram #(.WIDTH(pkv_pkg::SCORE_BITS), .DEPTH(pkv_pkg::RING_DEPTH)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (score_wdata),
    .raddr (score_raddr),
    .rdata (score_rdata)
  );

  pkv_ram #(.WIDTH(pkv_pkg::BLK_W), .DEPTH(pkv_pkg::NUM_BLOCKS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (ring_rdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_block_id = out_blk_r;
  assign out_offset   = out_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      max_act_r   <= '0;
      btok_r      <= pkv_pkg::BS_W'(16);
      nseq_r      <= pkv_pkg::NSEQ_W'(8);
      out_valid_r <= 1'b0;
      free_top_r  <= pkv_pkg::TOP_W'(pkv_pkg::NUM_BLOCKS);
      min_top_r   <= pkv_pkg::TOP_W'(pkv_pkg::NUM_BLOCKS);
      in_use_r    <= '0;
      for (int i = 0; i < pkv_pkg::NUM_SEQS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        scnt_r[i] <= '0;
        trim_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pkv_pkg::CFG_POLICY:     policy_r  <= cfg_data[0];
          pkv_pkg::CFG_MAX_BLOCKS: max_act_r <= cfg_data[pkv_pkg::MAXB_W-1:0];
          pkv_pkg::CFG_BLOCK_TOK:  btok_r    <= cfg_data;
          pkv_pkg::CFG_ACT_SEQS:   nseq_r    <= cfg_data[pkv_pkg::NSEQ_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once the consumer takes it.
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= pkv_pkg::kind_t'(in_kind);
            seq_r    <= in_seq;
            tok_r    <= in_token_pos;
            len_in_r <= in_new_length;
            sc_r     <= in_score;
            state_r  <= S_START;
          end
        end

        S_START: begin
          res_st_r  <= pkv_pkg::ST_OK;
          res_blk_r <= '0;
          res_off_r <= '0;
          behind_r  <= 1'b0;
          iter_r    <= pkv_pkg::ITER_W'(pkv_pkg::NUM_BLOCKS + 1);
          div_rem_r <= '0;
          div_cnt_r <= pkv_pkg::DIV_CNT_W'(pkv_pkg::TOK_W);
          if ({1'b0, seq_r} >= {1'b0, nseq_eff}) begin
            res_st_r <= pkv_pkg::ST_BADSEQ;
            state_r  <= S_DONE;
          end else begin
            case (kind_r)
              pkv_pkg::K_SETLEN: begin
                if (len_in_r < len_c) begin
                  free_i_r <= '0;
                  if (cnt_c == '0) begin
                    head_r[cidx] <= '0;
                    scnt_r[cidx] <= '0;
                    trim_r[cidx] <= '0;
                    len_r[cidx]  <= len_in_r;
                    state_r      <= S_DONE;
                  end else begin
                    state_r <= S_FREE_RD;
                  end
                end else begin
                  len_r[cidx] <= len_in_r;
                  if (trim_c > {1'b0, len_in_r}) begin
                    // Round the new trim down to a block boundary.
                    diff_r    <= shrink_t;
                    div_quo_r <= shrink_t;
                    state_r   <= S_DIV;
                  end else begin
                    state_r <= S_DONE;
                  end
                end
              end
              pkv_pkg::K_ENSURE: begin
                if (tok_behind) begin
                  res_st_r <= pkv_pkg::ST_UNMAPPED;
                  state_r  <= S_DONE;
                end else begin
                  diff_r    <= tok_diff;
                  div_quo_r <= tok_diff;
                  state_r   <= S_DIV;
                end
              end
              pkv_pkg::K_RESOLVE: begin
                if (tok_behind || (tok_r >= len_c)) begin
                  res_st_r <= pkv_pkg::ST_UNMAPPED;
                  state_r  <= S_DONE;
                end else begin
                  diff_r    <= tok_diff;
                  div_quo_r <= tok_diff;
                  state_r   <= S_DIV;
                end
              end
              default: begin
                if ((len_c == '0) || (cnt_c == '0)) begin
                  res_st_r <= pkv_pkg::ST_UNMAPPED;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_SC_PAD;
                end
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_cnt_r != '0) begin
            div_quo_r <= {div_quo_r[pkv_pkg::TOK_W-2:0], div_ge};
            div_rem_r <= div_ge ? div_sub[pkv_pkg::OFF_W-1:0] : div_sh[pkv_pkg::OFF_W-1:0];
            div_cnt_r <= div_cnt_r - pkv_pkg::DIV_CNT_W'(1);
          end else begin
            case (kind_r)
              pkv_pkg::K_SETLEN: begin
                trim_r[cidx] <= {1'b0, diff_r - pkv_pkg::TOK_W'(div_rem_r)};
                state_r      <= S_DONE;
              end
              pkv_pkg::K_ENSURE: begin
                state_r <= S_EN_CHK;
              end
              pkv_pkg::K_RESOLVE: begin
                if (div_quo_r >= pkv_pkg::TOK_W'(cnt_c)) begin
                  res_st_r <= pkv_pkg::ST_UNMAPPED;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_RD_BLK;
                end
              end
              default: begin
                if (div_quo_r >= pkv_pkg::TOK_W'(scnt_c)) begin
                  res_st_r <= pkv_pkg::ST_UNMAPPED;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_SC_UPD;
                end
              end
            endcase
          end
        end

        S_RD_BLK: begin
          res_blk_r <= ring_rdata;
          res_off_r <= div_rem_r;
          state_r   <= S_DONE;
        end

        S_FREE_RD: begin
          state_r <= S_FREE_WR;
        end

        S_FREE_WR: begin
          // Return the block to the stack unless it is already there.
          if (free_ok) begin
            in_use_r[ring_rdata] <= 1'b0;
            free_top_r           <= free_top_r + pkv_pkg::TOP_W'(1);
          end
          free_i_r <= free_i_r + pkv_pkg::RCNT_W'(1);
          if ((free_i_r + pkv_pkg::RCNT_W'(1)) == cnt_c) begin
            head_r[cidx] <= '0;
            cnt_r[cidx]  <= '0;
            scnt_r[cidx] <= '0;
            trim_r[cidx] <= '0;
            len_r[cidx]  <= len_in_r;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_FREE_RD;
          end
        end

        S_EN_CHK: begin
          if (behind_r) begin
            res_st_r <= pkv_pkg::ST_UNMAPPED;
            state_r  <= S_DONE;
          end else if (pkv_pkg::TOK_W'(cnt_c) > div_quo_r) begin
            state_r <= S_RD_BLK;
          end else if (iter_r == '0) begin
            res_st_r <= pkv_pkg::ST_UNMAPPED;
            state_r  <= S_DONE;
          end else begin
            iter_r <= iter_r - pkv_pkg::ITER_W'(1);
            if (cnt_c == pkv_pkg::RCNT_W'(pkv_pkg::MAX_SEQ_BLOCKS)) begin
              // Ring full: recycle our own front block.
              vic_r   <= s_idx;
              state_r <= S_VIC;
            end else if (need_steal) begin
              scan_r      <= '0;
              most_best_r <= s_idx;
              most_cnt_r  <= '0;
              sc_found_r  <= 1'b0;
              state_r     <= S_SCAN_RD;
            end else begin
              state_r <= S_ALLOC_RD;
            end
          end
        end

        S_ALLOC_RD: begin
          state_r <= S_ALLOC_WR;
        end

        S_ALLOC_WR: begin
          b_r                <= pop_blk;
          in_use_r[pop_blk]  <= 1'b1;
          free_top_r         <= top_dec;
          if (free_top_r == min_top_r) begin
            min_top_r <= top_dec;
          end
          state_r <= S_PUSH;
        end

        S_SCAN_RD: begin
          state_r <= S_SCAN_CMP;
        end

        S_SCAN_CMP: begin
          if (!sc_rank && (cnt_c != '0) && (cnt_c > most_cnt_r)) begin
            most_best_r <= scan_r;
            most_cnt_r  <= cnt_c;
          end
          if ((cnt_c != '0) && (scnt_c != '0) && sc_better) begin
            sc_found_r <= 1'b1;
            sc_best_r  <= scan_r;
            sc_rank_r  <= sc_rank;
            sc_val_r   <= score_rdata;
          end
          if (scan_last) begin
            state_r <= S_SCAN_END;
          end else begin
            scan_r  <= scan_r + pkv_pkg::SEQ_W'(1);
            state_r <= S_SCAN_RD;
          end
        end

        S_SCAN_END: begin
          vic_r   <= (policy_r && sc_found_r) ? sc_best_r : most_best_r;
          state_r <= S_VIC;
        end

        S_VIC: begin
          if (cnt_c == '0) begin
            res_st_r <= pkv_pkg::ST_NOVICTIM;
            state_r  <= S_DONE;
          end else begin
            // Trim the victim's front; the ring read is in flight.
            head_r[cidx] <= head_c + pkv_pkg::RIDX_W'(1);
            cnt_r[cidx]  <= cnt_c - pkv_pkg::RCNT_W'(1);
            if (scnt_c != '0) begin
              scnt_r[cidx] <= scnt_c - pkv_pkg::RCNT_W'(1);
            end
            trim_r[cidx] <= trim_inc;
            if (vic_r == s_idx) begin
              if (diff_r >= pkv_pkg::TOK_W'(bs)) begin
                diff_r    <= diff_r - pkv_pkg::TOK_W'(bs);
                div_quo_r <= div_quo_r - pkv_pkg::TOK_W'(1);
              end else begin
                behind_r <= 1'b1;
              end
            end
            state_r <= S_POP_DATA;
          end
        end

        S_POP_DATA: begin
          b_r     <= ring_rdata;
          state_r <= S_PUSH;
        end

        S_PUSH: begin
          cnt_r[cidx] <= cnt_c + pkv_pkg::RCNT_W'(1);
          state_r     <= S_EN_CHK;
        end

        S_SC_PAD: begin
          if (scnt_c < cnt_c) begin
            scnt_r[cidx] <= scnt_c + pkv_pkg::RCNT_W'(1);
          end else if (tok_behind || (tok_r >= len_c)) begin
            res_st_r <= pkv_pkg::ST_UNMAPPED;
            state_r  <= S_DONE;
          end else begin
            diff_r    <= tok_diff;
            div_quo_r <= tok_diff;
            state_r   <= S_DIV;
          end
        end

        S_SC_UPD: begin
          res_blk_r <= ring_rdata;
          res_off_r <= div_rem_r;
          state_r   <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_blk_r    <= (res_st_r == pkv_pkg::ST_OK) ? res_blk_r : '0;
            out_off_r    <= (res_st_r == pkv_pkg::ST_OK) ? res_off_r : '0;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/pkv_chk.sv */
// Port-level checker for the paged KV block allocator, bound to the top level.
module pkv_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [pkv_pkg::KIND_W-1:0]    in_kind,
  input logic [pkv_pkg::SEQIN_W-1:0]   in_seq,
  input logic [pkv_pkg::TOK_W-1:0]     in_token_pos,
  input logic [pkv_pkg::TOK_W-1:0]     in_new_length,
  input logic [pkv_pkg::SCIN_W-1:0]    in_score,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [pkv_pkg::BLK_W-1:0]     out_block_id,
  input logic [pkv_pkg::OFF_W-1:0]     out_offset,
  input logic                          cfg_we,
  input logic [pkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [pkv_pkg::CFG_W-1:0]     cfg_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_block_id) && $stable(out_offset))
    else $error("result changed while stalled");

  // Error results carry no block or offset.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pkv_pkg::ST_OK) |-> (out_block_id == '0) && (out_offset == '0))
    else $error("error result with nonzero payload");

  // The block does not stay ready after it accepts a transaction.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind paged_kv_block_allocator pkv_chk u_pkv_chk (.*);
